/* rtl/alle_pkg.sv */
// shared constants, codes and word types for the array linked list engine
package alle_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int STEP_W   = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 4;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LINK   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SENTINEL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic                    position_dir;
        logic [POS_W-1:0]        position;
        logic [KEY_W-1:0]        item_key;
        logic signed [VAL_W-1:0] item_value;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        result_position;
        logic [KEY_W-1:0]        out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [COUNT_W-1:0]      element_count;
    } t_rsp;

endpackage

/* rtl/array_linked_list_engine.sv */
// array based circular doubly linked list engine with free list
//
// Command word on i_cmd is taken at a rising edge with start high and busy low.
// The response word appears on o_rsp for one cycle with o_valid high; the
// receiver cannot stall it and must take it in that cycle.
// Slot 0 is the sentinel; keys, values and links live in four memories, each
// with one write and one registered read per cycle (keys and values share
// their addresses); a sequencer walks them.
// Set, sentinel errors, list full and unused modes answer from idle without
// raising busy; get and link read do one registered read, erase and insert
// step through link and free list updates, and find walks from the sentinel
// until a key match, a return to the sentinel or CAPACITY slots visited.
// busy is high while a command is in the sequencer and falls as its response
// appears, so one command is in flight at a time; throughput is bound by the
// link memory accesses.
// After reset a clearing pass writes each of the CAPACITY (16) slots in turn,
// loading the initial keys, values and links; busy is high during it and no
// command is taken.
module array_linked_list_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  alle_pkg::t_cmd  i_cmd,
    output logic            busy,
    output logic            o_valid,
    output alle_pkg::t_rsp  o_rsp
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INS_FREE,
        S_INS_READ,
        S_INS_LINK,
        S_INS_DONE,
        S_ERA_LINK,
        S_ERA_FREE,
        S_ERA_DONE,
        S_GET_OUT,
        S_LNK_OUT,
        S_FND_HEAD,
        S_FND_CHK,
        S_FND_CMP
    } t_state;

    localparam int IW = alle_pkg::IDX_W;
    localparam int KB = alle_pkg::KEY_BITS;
    localparam int VW = alle_pkg::VAL_W;

    t_state                         r_state, n_state;
    logic [IW-1:0]                  r_clr, n_clr;
    logic [IW-1:0]                  r_pos, n_pos;
    logic                           r_dir, n_dir;
    logic [KB-1:0]                  r_key, n_key;
    logic [VW-1:0]                  r_val, n_val;
    logic [IW-1:0]                  r_slot, n_slot;
    logic [IW-1:0]                  r_pa, n_pa;
    logic [IW-1:0]                  r_cur, n_cur;
    logic [alle_pkg::STEP_W-1:0]    r_steps, n_steps;
    logic [IW-1:0]                  r_fh, n_fh;
    logic [alle_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                           r_valid, n_valid;
    alle_pkg::t_rsp                 r_rsp, n_rsp;

    // memories
    logic [KB-1:0]  m_key  [alle_pkg::CAPACITY];
    logic [VW-1:0]  m_val  [alle_pkg::CAPACITY];
    logic [IW-1:0]  m_next [alle_pkg::CAPACITY];
    logic [IW-1:0]  m_prev [alle_pkg::CAPACITY];

    logic           kv_we;
    logic [IW-1:0]  kv_wa, kv_ra;
    logic [KB-1:0]  kv_wkey;
    logic [VW-1:0]  kv_wval;
    logic [KB-1:0]  r_key_rd;
    logic [VW-1:0]  r_val_rd;

    logic           nx_we;
    logic [IW-1:0]  nx_wa, nx_wd, nx_ra, r_next_rd;
    logic           pv_we;
    logic [IW-1:0]  pv_wa, pv_wd, pv_ra, r_prev_rd;

    logic [IW-1:0]              w_pos;
    logic [KB-1:0]              w_key;
    logic [alle_pkg::KEY_W-1:0] w_okey;
    logic                       w_accept;

    assign w_pos    = IW'(i_cmd.position);
    assign w_key    = i_cmd.item_key[KB-1:0];
    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        w_okey = '0;
        w_okey[KB-1:0] = r_key_rd;
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            m_key[kv_wa] <= kv_wkey;
            m_val[kv_wa] <= kv_wval;
        end
        r_key_rd <= m_key[kv_ra];
        r_val_rd <= m_val[kv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            m_next[nx_wa] <= nx_wd;
        end
        r_next_rd <= m_next[nx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            m_prev[pv_wa] <= pv_wd;
        end
        r_prev_rd <= m_prev[pv_ra];
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_pos   = r_pos;
        n_dir   = r_dir;
        n_key   = r_key;
        n_val   = r_val;
        n_slot  = r_slot;
        n_pa    = r_pa;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_fh    = r_fh;
        n_count = r_count;
        n_valid = 1'b0;
        n_rsp   = r_rsp;

        kv_we   = 1'b0;
        kv_wa   = r_pos;
        kv_ra   = r_pos;
        kv_wkey = r_key;
        kv_wval = r_val;
        nx_we   = 1'b0;
        nx_wa   = r_pos;
        nx_wd   = '0;
        nx_ra   = r_pos;
        pv_we   = 1'b0;
        pv_wa   = r_pos;
        pv_wd   = '0;
        pv_ra   = r_pos;

        case (r_state)
            S_CLR: begin
                kv_we   = 1'b1;
                kv_wa   = r_clr;
                kv_wkey = '0;
                kv_wval = '0;
                nx_we   = 1'b1;
                nx_wa   = r_clr;
                nx_wd   = (r_clr == '0 || r_clr == IW'(alle_pkg::CAPACITY - 1)) ? '0
                                                                             : r_clr + 1'b1;
                pv_we   = 1'b1;
                pv_wa   = r_clr;
                pv_wd   = (r_clr == '0) ? '0 : r_clr - 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IW'(alle_pkg::CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_pos = w_pos;
                    n_dir = i_cmd.position_dir;
                    n_key = w_key;
                    n_val = i_cmd.item_value;
                    n_rsp = '0;
                    n_rsp.element_count = r_count;
                    case (i_cmd.mode)
                        alle_pkg::MODE_INSERT: begin
                            if (r_fh == '0) begin
                                n_valid      = 1'b1;
                                n_rsp.status = alle_pkg::STAT_FULL;
                            end else begin
                                n_slot  = r_fh;
                                nx_ra   = r_fh;
                                n_state = S_INS_FREE;
                            end
                        end
                        alle_pkg::MODE_ERASE: begin
                            if (w_pos == '0) begin
                                n_valid      = 1'b1;
                                n_rsp.status = alle_pkg::STAT_SENTINEL;
                            end else begin
                                nx_ra   = w_pos;
                                pv_ra   = w_pos;
                                n_state = S_ERA_LINK;
                            end
                        end
                        alle_pkg::MODE_GET: begin
                            if (w_pos == '0) begin
                                n_valid      = 1'b1;
                                n_rsp.status = alle_pkg::STAT_SENTINEL;
                            end else begin
                                kv_ra   = w_pos;
                                n_state = S_GET_OUT;
                            end
                        end
                        alle_pkg::MODE_SET: begin
                            n_valid = 1'b1;
                            if (w_pos == '0) begin
                                n_rsp.status = alle_pkg::STAT_SENTINEL;
                            end else begin
                                kv_we   = 1'b1;
                                kv_wa   = w_pos;
                                kv_wkey = w_key;
                                kv_wval = i_cmd.item_value;
                            end
                        end
                        alle_pkg::MODE_LINK: begin
                            nx_ra   = w_pos;
                            pv_ra   = w_pos;
                            n_state = S_LNK_OUT;
                        end
                        alle_pkg::MODE_FIND: begin
                            nx_ra   = '0;
                            n_steps = '0;
                            n_state = S_FND_HEAD;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_FREE: begin
                n_fh = r_next_rd;
                if (r_next_rd != '0) begin
                    pv_we = 1'b1;
                    pv_wa = r_next_rd;
                    pv_wd = '0;
                end
                kv_we   = 1'b1;
                kv_wa   = r_slot;
                n_state = S_INS_READ;
            end
            S_INS_READ: begin
                pv_ra   = r_pos;
                n_state = S_INS_LINK;
            end
            S_INS_LINK: begin
                pv_we   = 1'b1;
                pv_wa   = r_slot;
                pv_wd   = r_prev_rd;
                nx_we   = 1'b1;
                nx_wa   = r_slot;
                nx_wd   = r_pos;
                n_pa    = r_prev_rd;
                n_state = S_INS_DONE;
            end
            S_INS_DONE: begin
                nx_we   = 1'b1;
                nx_wa   = r_pa;
                nx_wd   = r_slot;
                pv_we   = 1'b1;
                pv_wa   = r_pos;
                pv_wd   = r_slot;
                n_count = (r_count == alle_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
                n_valid = 1'b1;
                n_rsp.result_position = alle_pkg::POS_W'(r_slot);
                n_rsp.element_count   = n_count;
                n_state = S_IDLE;
            end
            S_ERA_LINK: begin
                nx_we   = 1'b1;
                nx_wa   = r_prev_rd;
                nx_wd   = r_next_rd;
                pv_we   = 1'b1;
                pv_wa   = r_next_rd;
                pv_wd   = r_prev_rd;
                kv_we   = 1'b1;
                kv_wa   = r_pos;
                kv_wkey = '0;
                kv_wval = '0;
                n_state = S_ERA_FREE;
            end
            S_ERA_FREE: begin
                if (r_fh != '0) begin
                    pv_we = 1'b1;
                    pv_wa = r_fh;
                    pv_wd = r_pos;
                end
                nx_we   = 1'b1;
                nx_wa   = r_pos;
                nx_wd   = r_fh;
                n_state = S_ERA_DONE;
            end
            S_ERA_DONE: begin
                pv_we   = 1'b1;
                pv_wa   = r_pos;
                pv_wd   = '0;
                n_fh    = r_pos;
                n_count = (r_count == '0) ? r_count : r_count - 1'b1;
                n_valid = 1'b1;
                n_rsp.element_count = n_count;
                n_state = S_IDLE;
            end
            S_GET_OUT: begin
                n_valid         = 1'b1;
                n_rsp.out_key   = w_okey;
                n_rsp.out_value = r_val_rd;
                n_state         = S_IDLE;
            end
            S_LNK_OUT: begin
                n_valid = 1'b1;
                n_rsp.result_position = alle_pkg::POS_W'(r_dir ? r_prev_rd : r_next_rd);
                n_state = S_IDLE;
            end
            S_FND_HEAD: begin
                n_cur   = r_next_rd;
                n_state = S_FND_CHK;
            end
            S_FND_CHK: begin
                if (r_cur == '0 || r_steps == alle_pkg::STEP_W'(alle_pkg::CAPACITY)) begin
                    n_valid      = 1'b1;
                    n_rsp.status = alle_pkg::STAT_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    kv_ra   = r_cur;
                    nx_ra   = r_cur;
                    n_state = S_FND_CMP;
                end
            end
            S_FND_CMP: begin
                if (r_key_rd == r_key) begin
                    n_valid = 1'b1;
                    n_rsp.result_position = alle_pkg::POS_W'(r_cur);
                    n_state = S_IDLE;
                end else begin
                    n_cur   = r_next_rd;
                    n_steps = r_steps + 1'b1;
                    n_state = S_FND_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_dir   <= n_dir;
        r_key   <= n_key;
        r_val   <= n_val;
        r_slot  <= n_slot;
        r_pa    <= n_pa;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_rsp   <= n_rsp;
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_fh    <= IW'(1);
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fh    <= n_fh;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // response comes with the sequencer back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("response word while sequencer busy");

    // an accepted word either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_valid))
        else $error("accepted word neither answered nor in progress");

    // every command that ends answers in that cycle
    a_end_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(busy) && $past(r_state) != S_CLR) |-> o_valid)
        else $error("command ended without a response word");

endmodule
